FILE: rtl/pli_pkg.sv
// ----------------------------------------------------------------------------
// pli_pkg
// Shared types and constants for the piecewise linear interpolator.
// ----------------------------------------------------------------------------
package pli_pkg;

	localparam int unsigned MaxNodesDefault = 64;
	localparam int unsigned ValW = 32;

	typedef enum logic [1:0] {
		MODE_CLEAR = 2'd0,
		MODE_LOAD  = 2'd1,
		MODE_QUERY = 2'd2,
		MODE_NONE  = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_DUP   = 2'd2,
		ST_FULL  = 2'd3
	} status_t;

	typedef struct packed {
		logic [1:0]             mode;
		logic signed [ValW-1:0] x_value;
		logic signed [ValW-1:0] y_value;
	} in_item_t;

	typedef struct packed {
		logic signed [ValW-1:0] result_value;
		logic [1:0]             status;
	} out_item_t;

	// Sequencer states
	typedef enum logic [3:0] {
		S_IDLE,
		S_INS_RD,
		S_INS_CMP,
		S_INS_WR,
		S_Q_RD,
		S_Q_CMP,
		S_Q_RD2,
		S_Q_PRE,
		S_Q_MUL,
		S_Q_DIV,
		S_Q_FIN,
		S_OUT
	} state_t;

	// Divider handshake
	typedef struct packed {
		logic start;
	} div_ctl_t;

endpackage

FILE: rtl/pli_stream_if.sv
// ----------------------------------------------------------------------------
// pli_stream_if
// Valid/ready channel carrying one payload beat.
// ----------------------------------------------------------------------------
interface pli_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/pli_div.sv
// ----------------------------------------------------------------------------
// pli_div
// Restoring divider, one quotient bit per cycle, unsigned 64 / 33.
// ----------------------------------------------------------------------------
module pli_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  pli_pkg::div_ctl_t             ctl,
	input  logic [63:0]                   dividend,
	input  logic [32:0]                   divisor,
	output logic                          done,
	output logic [63:0]                   quotient
);
	import pli_pkg::*;

	logic [63:0] quo_q;
	logic [32:0] rem_q;
	logic [32:0] div_q;
	logic [6:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [33:0] trial;
	logic [33:0] diff;

	assign trial = {rem_q, quo_q[63]};
	assign diff  = trial - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && !ctl.start && (cnt_q == 7'd1);
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 7'd64;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			if (!diff[33]) begin
				rem_q <= diff[32:0];
				quo_q <= {quo_q[62:0], 1'b1};
			end else begin
				rem_q <= trial[32:0];
				quo_q <= {quo_q[62:0], 1'b0};
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;
endmodule

FILE: rtl/pli_mul.sv
// ----------------------------------------------------------------------------
// pli_mul
// 33x33 unsigned multiply as 33x17 and 33x16 halves, one per enabled cycle.
// ----------------------------------------------------------------------------
module pli_mul (
	input  logic        clk,
	input  logic        lo_en,
	input  logic        hi_en,
	input  logic [32:0] a,
	input  logic [32:0] b,
	output logic [65:0] product
);
	logic [49:0] lo_q;
	logic [65:0] prod_q;
	logic [49:0] lo_part;
	logic [48:0] hi_part;

	assign lo_part = a * b[16:0];
	assign hi_part = a * b[32:17];

	always_ff @(posedge clk) begin
		if (lo_en) lo_q <= lo_part;
		if (hi_en) prod_q <= {16'd0, lo_q} + {hi_part, 17'd0};
	end

	assign product = prod_q;
endmodule

FILE: rtl/piecewise_linear_interpolator.sv
// ----------------------------------------------------------------------------
// piecewise_linear_interpolator
// Sorted node table in RAM; insertion on load, binary search, multiply and divide on query.
// ----------------------------------------------------------------------------
// channel   dir   payload
// in_ch     in    mode, x_value, y_value
// out_ch    out   result_value, status
//
// One item at a time.
// Clear, mode 3, full load, and query on an empty or flagged table go straight to the output.
// Load: reads down from the top, moving each larger entry up one slot, then writes the node.
// Query: binary search (up to clog2(MAX_NODES + 1) steps), then reads of the two
// bracketing nodes, both multiply halves and a restoring divide.
// Reset empties the table count at once. Result holds until taken; input reopens next cycle.
module piecewise_linear_interpolator #(
	parameter int unsigned MAX_NODES = pli_pkg::MaxNodesDefault
) (
	input  logic       clk,
	input  logic       arst_n,
	pli_stream_if.sink   in_ch,
	pli_stream_if.source out_ch
);
	import pli_pkg::*;

	localparam int unsigned AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
	localparam int unsigned CW = $clog2(MAX_NODES + 1);

	state_t state_q, state_d;

	logic signed [31:0] mem_x [MAX_NODES];
	logic signed [31:0] mem_y [MAX_NODES];
	logic [AW-1:0]      raddr;
	logic signed [31:0] rx_q, ry_q;
	logic               we;
	logic [AW-1:0]      waddr;
	logic signed [31:0] wx, wy;

	logic [CW-1:0] count_q;
	logic          dup_q;
	logic [CW-1:0] pos_q, lo_q, hi_q;
	logic signed [31:0] xv_q, yv_q;
	logic signed [31:0] x0_q, y0_q;
	logic [32:0]  dx_q, off_q, mag_q;
	logic [32:0]  dy;
	logic         neg_q;
	logic         oval_q;
	out_item_t    out_q;
	logic signed [31:0] fin_val;
	logic [CW-1:0] mid;
	logic         mul_lo, mul_hi;
	logic [65:0]  prod;
	div_ctl_t     dctl;
	logic         ddone;
	logic [63:0]  quo;
	logic [64:0]  sum;
	logic         in_fire;
	logic         dctl_pend_q, mulh_q;
	logic         hit_q, lo_edge_q;

	assign in_fire = in_ch.valid && in_ch.ready;
	assign in_ch.ready = (state_q == S_IDLE) && !oval_q;
	assign out_ch.valid = oval_q;
	assign out_ch.data  = out_q;
	assign mid = lo_q + ((hi_q - lo_q) >> 1);

	always_ff @(posedge clk) begin
		if (we) begin
			mem_x[waddr] <= wx;
			mem_y[waddr] <= wy;
		end
		rx_q <= mem_x[raddr];
		ry_q <= mem_y[raddr];
	end

	pli_mul u_mul (
		.clk(clk), .lo_en(mul_lo), .hi_en(mul_hi),
		.a(mag_q), .b(off_q), .product(prod)
	);

	pli_div u_div (
		.clk(clk), .arst_n(arst_n), .ctl(dctl),
		.dividend(prod[63:0] + {32'd0, dx_q[32:1]}), .divisor(dx_q),
		.done(ddone), .quotient(quo)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: if (in_fire) begin
				case (mode_t'(in_ch.data.mode))
					MODE_LOAD:  state_d = (count_q >= CW'(MAX_NODES)) ? S_OUT : S_INS_RD;
					MODE_QUERY: state_d = (dup_q || count_q == '0) ? S_OUT : S_Q_RD;
					default:    state_d = S_OUT;
				endcase
			end
			S_INS_RD:  state_d = (pos_q == '0) ? S_INS_WR : S_INS_CMP;
			S_INS_CMP: state_d = (rx_q > xv_q) ? S_INS_RD : S_INS_WR;
			S_INS_WR:  state_d = S_OUT;
			S_Q_RD:    state_d = (lo_q < hi_q) ? S_Q_CMP : S_Q_RD2;
			S_Q_CMP:   state_d = S_Q_RD;
			S_Q_RD2:   state_d = S_Q_PRE;
			S_Q_PRE:   state_d = S_Q_MUL;
			S_Q_MUL:   state_d = S_Q_DIV;
			S_Q_DIV:   state_d = ddone ? S_Q_FIN : S_Q_DIV;
			S_Q_FIN:   state_d = S_OUT;
			S_OUT:     state_d = S_IDLE;
			default:   state_d = S_IDLE;
		endcase
	end

	// Memory addresses and write strobes, multiplier enables and divider start
	always_comb begin
		raddr  = '0;
		we     = 1'b0;
		waddr  = pos_q[AW-1:0];
		wx     = rx_q;
		wy     = ry_q;
		mul_lo = 1'b0;
		mul_hi = 1'b0;
		dctl.start = 1'b0;
		case (state_q)
			S_INS_RD:  raddr = pos_q[AW-1:0] - AW'(1);
			S_INS_CMP: begin
				if (rx_q > xv_q) we = 1'b1;
			end
			S_INS_WR: begin
				we = 1'b1;
				wx = xv_q;
				wy = yv_q;
			end
			S_Q_RD: begin
				if (lo_q < hi_q) raddr = mid[AW-1:0];
				else if (lo_q != '0) raddr = lo_q[AW-1:0] - AW'(1);
			end
			S_Q_CMP: raddr = lo_q[AW-1:0];
			S_Q_RD2: raddr = lo_q[AW-1:0];
			S_Q_MUL: mul_lo = 1'b1;
			S_Q_DIV: begin
				mul_hi     = mulh_q;
				dctl.start = dctl_pend_q;
			end
			default: ;
		endcase
	end

	assign dy  = {ry_q[31], ry_q} - {y0_q[31], y0_q};
	assign sum = {{33{y0_q[31]}}, y0_q} + (neg_q ? -{1'b0, quo} : {1'b0, quo});
	always_comb begin
		fin_val = 32'(sum);
		if (!sum[64] && sum[63:31] != '0) fin_val = 32'h7fffffff;
		if (sum[64] && sum[63:31] != '1) fin_val = 32'sh80000000;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			dup_q       <= 1'b0;
			oval_q      <= 1'b0;
			dctl_pend_q <= 1'b0;
			mulh_q      <= 1'b0;
		end else begin
			state_q     <= state_d;
			// low half of the product lands first, then the high half; divider starts in the cycle after the high half
			mulh_q      <= (state_q == S_Q_MUL);
			dctl_pend_q <= mulh_q;
			if (out_ch.valid && out_ch.ready) oval_q <= 1'b0;
			if (state_q == S_OUT) oval_q <= 1'b1;
			if (in_fire && mode_t'(in_ch.data.mode) == MODE_CLEAR) begin
				count_q <= '0;
				dup_q   <= 1'b0;
			end
			if (state_q == S_INS_RD && pos_q == '0) count_q <= count_q + CW'(1);
			if (state_q == S_INS_CMP && !(rx_q > xv_q)) begin
				count_q <= count_q + CW'(1);
				if (rx_q == xv_q) dup_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			xv_q   <= in_ch.data.x_value;
			yv_q   <= in_ch.data.y_value;
			pos_q  <= count_q;
			lo_q   <= '0;
			hi_q   <= count_q;
			out_q.result_value <= '0;
			case (mode_t'(in_ch.data.mode))
				MODE_LOAD:  out_q.status <= (count_q >= CW'(MAX_NODES)) ? ST_FULL :
					(dup_q ? ST_DUP : ST_OK);
				MODE_QUERY: out_q.status <= dup_q ? ST_DUP :
					((count_q == '0) ? ST_RANGE : ST_OK);
				default:    out_q.status <= ST_OK;
			endcase
		end
		case (state_q)
			S_INS_CMP: begin
				if (rx_q > xv_q) pos_q <= pos_q - CW'(1);
				else if (rx_q == xv_q) out_q.status <= ST_DUP;
			end
			S_Q_RD: if (lo_q >= hi_q) begin
				// lo = first index with x >= a; raddr read x[lo-1] (x[0] when lo is 0)
				hit_q     <= 1'b0;
				lo_edge_q <= (lo_q == count_q) || (lo_q == '0);
			end
			S_Q_CMP: begin
				if (rx_q < xv_q) lo_q <= mid + CW'(1);
				else hi_q <= mid;
			end
			S_Q_RD2: begin
				x0_q <= rx_q;
				y0_q <= ry_q;
			end
			S_Q_PRE: begin
				// rx/ry now hold node lo
				if (lo_edge_q && !(lo_q == '0 && rx_q == xv_q)) begin
					out_q.status <= ST_RANGE;
				end else if (rx_q == xv_q) begin
					out_q.result_value <= ry_q;
				end
				hit_q <= lo_edge_q || (rx_q == xv_q);
				dx_q  <= 33'({rx_q[31], rx_q} - {x0_q[31], x0_q});
				off_q <= 33'({xv_q[31], xv_q} - {x0_q[31], x0_q});
				neg_q <= dy[32];
				mag_q <= dy[32] ? -dy : dy;
			end
			S_Q_FIN: if (!hit_q) out_q.result_value <= fin_val;
			default: ;
		endcase
	end
endmodule

FILE: tb/sv/piecewise_linear_interpolator_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// piecewise_linear_interpolator_tb
// Self-checking bench: drives clear/load/query/none beats with random gaps,
// keeps a local sorted node table and interpolation predictor, and compares
// every output beat against the oldest predicted answer.
// ----------------------------------------------------------------------------
module piecewise_linear_interpolator_tb;
	import pli_pkg::*;

	localparam int Depth = 64;
	localparam int IdleLimit = 20000;

	logic clk;
	logic arst_n;

	pli_stream_if #(.payload_t(in_item_t))  in_ch ();
	pli_stream_if #(.payload_t(out_item_t)) out_ch ();

	piecewise_linear_interpolator #(.MAX_NODES(Depth)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	in_item_t  pending_beats[$];
	out_item_t expected_answers[$];
	int        error_count = 0;
	int        idle_cycles = 0;
	bit        calm = 0;

	// predictor copy of the node table
	logic signed [31:0] tbl_x[Depth];
	logic signed [31:0] tbl_y[Depth];
	int                 tbl_count = 0;
	bit                 tbl_dup = 0;

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic signed [31:0] interpolate(int i, logic signed [31:0] a);
		longint dy, r;
		longint unsigned dx, off, mag, q;
		bit neg;
		dy = longint'(tbl_y[i+1]) - longint'(tbl_y[i]);
		dx = longint'(tbl_x[i+1]) - longint'(tbl_x[i]);
		off = longint'(a) - longint'(tbl_x[i]);
		neg = dy < 0;
		mag = neg ? -dy : dy;
		q = (mag * off + dx / 2) / dx;
		r = longint'(tbl_y[i]) + (neg ? -longint'(q) : longint'(q));
		if (r > 64'sd2147483647) r = 64'sd2147483647;
		if (r < -64'sd2147483648) r = -64'sd2147483648;
		return r[31:0];
	endfunction

	function automatic out_item_t compute_answer(in_item_t it);
		out_item_t o;
		int pos, lo, hi, mid;
		o.result_value = '0;
		o.status = ST_OK;
		case (mode_t'(it.mode))
			MODE_CLEAR: begin
				tbl_count = 0;
				tbl_dup = 0;
			end
			MODE_LOAD: begin
				if (tbl_count >= Depth) begin
					o.status = ST_FULL;
				end else begin
					pos = tbl_count;
					while (pos > 0 && tbl_x[pos-1] > it.x_value) begin
						tbl_x[pos] = tbl_x[pos-1];
						tbl_y[pos] = tbl_y[pos-1];
						pos--;
					end
					if (pos > 0 && tbl_x[pos-1] == it.x_value) tbl_dup = 1;
					tbl_x[pos] = it.x_value;
					tbl_y[pos] = it.y_value;
					tbl_count++;
					o.status = tbl_dup ? ST_DUP : ST_OK;
				end
			end
			MODE_QUERY: begin
				if (tbl_dup) begin
					o.status = ST_DUP;
				end else begin
					lo = 0;
					hi = tbl_count;
					while (lo < hi) begin
						mid = lo + (hi - lo) / 2;
						if (tbl_x[mid] < it.x_value) lo = mid + 1;
						else hi = mid;
					end
					if (tbl_count == 0 || lo >= tbl_count ||
					    (lo == 0 && it.x_value < tbl_x[0]))
						o.status = ST_RANGE;
					else if (tbl_x[lo] == it.x_value)
						o.result_value = tbl_y[lo];
					else
						o.result_value = interpolate(lo - 1, it.x_value);
				end
			end
			default: ;
		endcase
		return o;
	endfunction

	task automatic report(string what, out_item_t got, out_item_t want);
		error_count++;
		$display("MISMATCH %s: got value %h status %0d, want value %h status %0d",
			what, got.result_value, got.status, want.result_value, want.status);
	endtask

	// driver
	int in_gap = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.data  <= '0;
		end else begin
			if (in_ch.valid && in_ch.ready)
				expected_answers.insert(expected_answers.size(),
					compute_answer(in_ch.data));
			if (!in_ch.valid || in_ch.ready) begin
				if (in_gap > 0) begin
					in_gap--;
					in_ch.valid <= 1'b0;
				end else if (pending_beats.size() > 0) begin
					in_ch.valid <= 1'b1;
					in_ch.data  <= pending_beats.pop_front();
					in_gap = pick_gap();
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	int out_gap = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				if (expected_answers.size() == 0)
					report("unexpected beat", out_ch.data, '0);
				else if (out_ch.data !== expected_answers[0])
					report("wrong answer", out_ch.data, expected_answers.pop_front());
				else
					void'(expected_answers.pop_front());
			end
			if (out_gap > 0) begin
				out_gap--;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= 1'b1;
				out_gap = pick_gap();
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IdleLimit) begin
			$display("piecewise_linear_interpolator regression: fail");
			$finish;
		end
	end

	task automatic add(mode_t m, logic signed [31:0] x, logic signed [31:0] y);
		in_item_t it;
		it.mode = m;
		it.x_value = x;
		it.y_value = y;
		pending_beats.insert(pending_beats.size(), it);
	endtask

	function automatic logic signed [31:0] rand_x();
		if ($urandom_range(0, 1)) return $urandom;
		return $signed($urandom_range(0, 4000)) - 2000;
	endfunction

	task automatic build_stimulus();
		int total, n, m, k;
		logic signed [31:0] xs[$];
		logic signed [31:0] xmin, xmax, x;
		longint unsigned span;
		// directed
		add(MODE_QUERY, 32'sd0, 32'sd0);
		add(MODE_LOAD, 32'sd100, 32'sh7fffffff);
		add(MODE_QUERY, 32'sd100, 32'sd0);
		add(MODE_QUERY, 32'sd101, 32'sd0);
		add(MODE_LOAD, 32'sh80000000, 32'sh80000000);
		add(MODE_LOAD, 32'sh7fffffff, 32'sh7fffffff);
		add(MODE_QUERY, 32'sh80000000, 32'sd0);
		add(MODE_QUERY, 32'sh7fffffff, 32'sd0);
		add(MODE_QUERY, 32'sd0, 32'sd0);
		add(MODE_QUERY, 32'sd50, 32'sd0);
		add(MODE_QUERY, 32'sd200, 32'sd0);
		add(MODE_NONE, 32'sh7fffffff, 32'sh80000000);
		add(MODE_CLEAR, 32'sd0, 32'sd0);
		add(MODE_LOAD, -32'sd65536, 32'sh80000000);
		add(MODE_LOAD, 32'sd65536, 32'sh7fffffff);
		add(MODE_QUERY, 32'sd0, 32'sd0);
		add(MODE_QUERY, 32'sd1, 32'sd0);
		add(MODE_QUERY, -32'sd65537, 32'sd0);
		add(MODE_QUERY, 32'sd65537, 32'sd0);
		add(MODE_LOAD, 32'sd65536, 32'sd5);
		add(MODE_QUERY, 32'sd0, 32'sd0);
		add(MODE_LOAD, 32'sd7, 32'sd7);
		add(MODE_CLEAR, 32'sd0, 32'sd0);
		add(MODE_QUERY, 32'sd0, 32'sd0);
		total = pending_beats.size();
		// random sequences
		while (total < 1800) begin
			if ($urandom_range(0, 9) < 8) begin
				add(MODE_CLEAR, $urandom, $urandom);
				n = ($urandom_range(0, 29) == 0) ? 66 : $urandom_range(1, 12);
				xs.delete();
				for (int i = 0; i < n; i++) begin
					x = rand_x();
					if (xs.size() > 0 && $urandom_range(0, 19) == 0)
						x = xs[$urandom_range(0, xs.size() - 1)];
					xs.insert(xs.size(), x);
					add(MODE_LOAD, x, $urandom);
				end
				xmin = xs[0];
				xmax = xs[0];
				foreach (xs[j]) begin
					if (xs[j] < xmin) xmin = xs[j];
					if (xs[j] > xmax) xmax = xs[j];
				end
				span = longint'(xmax) - longint'(xmin) + 1;
				m = $urandom_range(1, 12);
				for (int i = 0; i < m; i++) begin
					k = $urandom_range(0, 9);
					if (k < 6)
						x = 32'(longint'(xmin) + longint'({$urandom, $urandom} % span));
					else if (k < 8)
						x = xs[$urandom_range(0, xs.size() - 1)];
					else
						x = $urandom;
					add(MODE_QUERY, x, $urandom);
				end
				total += 1 + n + m;
			end else begin
				n = $urandom_range(1, 6);
				for (int i = 0; i < n; i++)
					add(mode_t'($urandom_range(0, 3)), $urandom, $urandom);
				total += n;
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		build_stimulus();
		repeat (7) @(posedge clk);
		arst_n = 1'b1;
		fork
			forever begin
				repeat ($urandom_range(200, 2000)) @(posedge clk);
				calm = ~calm;
			end
		join_none
		wait (pending_beats.size() == 0);
		@(posedge clk);
		while (in_ch.valid) @(posedge clk);
		while (expected_answers.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
		if (error_count == 0 && expected_answers.size() == 0)
			$display("piecewise_linear_interpolator regression: pass");
		else
			$display("piecewise_linear_interpolator regression: fail");
		$finish;
	end
endmodule

FILE: files.f
rtl/pli_pkg.sv
rtl/pli_stream_if.sv
rtl/pli_div.sv
rtl/pli_mul.sv
rtl/piecewise_linear_interpolator.sv
tb/sv/piecewise_linear_interpolator_tb.sv
